// File: hw/rtl/tegf_pkg.sv
// Shared types and codes for the track excerpt group filter.
// Used by the core, the flag store, the result queue and the top level.
package tegf_pkg;

  // Grouping kind codes, same encoding on input and output.
  localparam logic [1:0] KIND_UNGROUPED = 2'd0;
  localparam logic [1:0] KIND_START     = 2'd1;
  localparam logic [1:0] KIND_END       = 2'd2;
  localparam logic [1:0] KIND_ENCLOSED  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_WINDOW_START  = 1'b0;
  localparam logic CFG_WINDOW_LENGTH = 1'b1;

  // Result queue depth and pointer width.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;

  typedef struct packed {
    logic at_end;
    logic at_start;
  } grp_flags_t;

  typedef struct packed {
    logic [23:0] delta;
    logic [1:0]  kind;
    logic [1:0]  cat;
    logic [7:0]  val;
    logic [31:0] payload;
    logic        last;
  } evt_t;

  typedef struct packed {
    logic [31:0] delta;
    logic [1:0]  kind;
    logic [1:0]  cat;
    logic [7:0]  val;
    logic [31:0] payload;
    logic        track_end;
    logic [31:0] length;
  } res_t;

  // Up to two results leave the core per event.
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } res_push_t;

endpackage

// File: hw/rtl/tegf_flag_mem.sv
// Per-group flag store: open-at-start and open-at-end bits for every group key.
// Registered read with write forwarding, and a clearing pass after reset and on request.
module tegf_flag_mem
  import tegf_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr_start,
  output logic             clr_busy,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output grp_flags_t       rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  grp_flags_t       wr_data
);

  grp_flags_t    mem [DEPTH];
  grp_flags_t    rd_data_r;
  logic          busy_r;
  logic [AW-1:0] clr_addr_r;

  logic          we;
  logic [AW-1:0] wa;
  grp_flags_t    wd;

  always_comb begin
    if (busy_r) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // A read in the same cycle as a write to the same key sees the new flags.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_start) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign clr_busy = busy_r;
  assign rd_data  = rd_data_r;

`ifndef SYNTHESIS
  a_no_read_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !rd_en)
    else $error("flag store read during clearing pass");
`endif

endmodule

// File: hw/rtl/tegf_core.sv
// Event filter core: window phase tracking, time accounting and result forming.
// Works on the registered event and its group flags; depends on tegf_pkg.
module tegf_core
  import tegf_pkg::*;
#(
  parameter int CNT_W = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        evt_valid,
  input  evt_t        evt,
  input  grp_flags_t  flags,
  input  logic        space_ok,
  input  logic [31:0] win_start,
  input  logic [31:0] win_len,
  input  logic [32:0] win_end,
  output logic        fire,
  output grp_flags_t  flags_nxt,
  output res_push_t   push
);

  typedef enum logic [1:0] {
    PH_BEFORE,
    PH_INSIDE,
    PH_AFTER
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [32:0]        tp_r, tp_nxt;
  logic               fp_r, fp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [33:0]        t_sum;
  logic [32:0]        t;
  logic [32:0]        ws33;
  logic [32:0]        gap;
  grp_flags_t         f;
  logic               skip;
  logic               emit;
  logic [31:0]        ev_delta;
  res_t               ev_res;
  res_t               end_res;

  assign fire  = evt_valid && space_ok;
  assign ws33  = {1'b0, win_start};
  assign t_sum = {1'b0, tp_r} + 34'(evt.delta);
  assign t     = t_sum[33] ? '1 : t_sum[32:0];
  assign gap   = win_end - tp_r;

  always_comb begin
    phase_nxt = phase_r;
    tp_nxt    = tp_r;
    fp_nxt    = fp_r;
    cnt_nxt   = cnt_r;
    f         = flags;
    skip      = 1'b0;
    emit      = 1'b0;
    ev_delta  = '0;

    if (phase_nxt == PH_BEFORE) begin
      if (t < ws33) begin
        if (evt.kind == KIND_START) begin
          f.at_start = 1'b1;
        end else if (evt.kind == KIND_END) begin
          f.at_start = 1'b0;
        end
        tp_nxt = t;
      end else begin
        phase_nxt = PH_INSIDE;
      end
    end

    if (phase_nxt == PH_INSIDE) begin
      if (t < win_end) begin
        case (evt.kind)
          KIND_START: begin
            if (!f.at_end) begin
              f.at_end = 1'b1;
              cnt_nxt  = cnt_r + CNT_W'(1);
            end
          end
          KIND_END: begin
            // Groups opened before the window close silently.
            if (f.at_start) begin
              f.at_start = 1'b0;
              skip       = 1'b1;
            end else if (f.at_end) begin
              f.at_end = 1'b0;
              cnt_nxt  = cnt_r - CNT_W'(1);
            end
          end
          KIND_ENCLOSED: begin
            if (f.at_start) begin
              skip = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (!skip) begin
          emit = 1'b1;
          if (fp_r) begin
            ev_delta = (t >= ws33) ? 32'(t - ws33) : '0;
            fp_nxt   = 1'b0;
          end else begin
            ev_delta = {8'd0, evt.delta};
          end
        end
        tp_nxt = t;
      end else begin
        phase_nxt = PH_AFTER;
        fp_nxt    = 1'b1;
      end
    end

    if (phase_nxt == PH_AFTER) begin
      if ((cnt_r != '0) && (evt.kind == KIND_END) && f.at_end) begin
        f.at_end = 1'b0;
        cnt_nxt  = cnt_r - CNT_W'(1);
        emit     = 1'b1;
        if (fp_nxt) begin
          // The first closing end lands on the window end.
          if (win_end > tp_r) begin
            ev_delta = gap[32] ? '1 : gap[31:0];
          end
          fp_nxt = 1'b0;
        end
      end
    end

    if (evt.last) begin
      phase_nxt = PH_BEFORE;
      tp_nxt    = '0;
      fp_nxt    = 1'b1;
      cnt_nxt   = '0;
    end
  end

  always_comb begin
    ev_res           = '0;
    ev_res.delta     = ev_delta;
    ev_res.kind      = evt.kind;
    ev_res.cat       = evt.cat;
    ev_res.val       = evt.val;
    ev_res.payload   = evt.payload;
    end_res          = '0;
    end_res.track_end = 1'b1;
    end_res.length   = win_len;

    push    = '0;
    push.r1 = end_res;
    if (emit) begin
      push.r0 = ev_res;
    end else begin
      push.r0 = end_res;
    end
    if (fire) begin
      push.num = 2'(emit) + 2'(evt.last);
    end
  end

  assign flags_nxt = f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BEFORE;
      tp_r    <= '0;
      fp_r    <= 1'b1;
      cnt_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      tp_r    <= tp_nxt;
      fp_r    <= fp_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_before_no_open: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BEFORE) |-> (cnt_r == '0))
    else $error("groups counted open at end before the window");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && evt.last) |=> (phase_r == PH_BEFORE) && (tp_r == '0) && fp_r)
    else $error("state not cleared after last event");
`endif

endmodule

// File: hw/rtl/tegf_out_fifo.sv
// Result queue: takes up to two results per cycle and hands out one per request.
// Decouples the core from output back-pressure; depends on tegf_pkg.
module tegf_out_fifo
  import tegf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  res_push_t push,
  output logic      space_ok,
  output logic      out_valid,
  input  logic      out_ready,
  output res_t      out_res
);

  res_t                 mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r;
  logic [OUT_PTR_W-1:0] rd_ptr_r;
  logic [OUT_PTR_W:0]   cnt_r;
  logic                 pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign space_ok  = (cnt_r <= (OUT_PTR_W + 1)'(OUT_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_r + OUT_PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(push.num);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      end
      cnt_r <= cnt_r + (OUT_PTR_W + 1)'(push.num) - (OUT_PTR_W + 1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num != 2'd0) |-> space_ok)
    else $error("result queue written without room");
`endif

endmodule

// File: hw/rtl/track_excerpt_group_filter_unit.sv
// Track excerpt group filter: passes the sequencer events that fall in the window
// [window_start, window_start + window_length), rebasing the first kept delta, then
// the ends of groups still open at the window end, then an end marker on the last
// event. It takes one event per clock while the output queue has room and no last
// event or clearing pass holds it off; an accepted event is registered and goes to
// the output queue once there is room, giving zero, one or two results, which leave
// at one per cycle while out_ready is high. The per-group flag store has one read
// port and one write port: flags are read as an event is accepted and written back
// as it goes to the queue, with forwarding between back-to-back events on the same
// group. The store is cleared after reset and every last event, with in_ready low.
// Depends on tegf_pkg, tegf_flag_mem, tegf_core and tegf_out_fifo.
module track_excerpt_group_filter_unit
  import tegf_pkg::*;
#(
  parameter int NUM_CATEGORIES   = 4,
  parameter int NUM_GROUP_VALUES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_delta_ticks,
  input  logic [1:0]  in_grouping_kind,
  input  logic [1:0]  in_group_category,
  input  logic [7:0]  in_group_value,
  input  logic [31:0] in_event_payload,
  input  logic        in_is_last_event,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_delta_ticks,
  output logic [1:0]  out_grouping_kind,
  output logic [1:0]  out_category,
  output logic [7:0]  out_group_value,
  output logic [31:0] out_payload,
  output logic        out_is_track_end,
  output logic [31:0] out_excerpt_length,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int NUM_GROUPS = NUM_CATEGORIES * NUM_GROUP_VALUES;
  localparam int KEY_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CNT_W      = $clog2(NUM_GROUPS + 1);

  // Remainder by a constant through shifted compare-and-subtract steps.
  function automatic logic [7:0] mod_const(input logic [7:0] v, input int m);
    int r;
    r = int'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (m << k)) begin
        r = r - (m << k);
      end
    end
    return 8'(r);
  endfunction

  logic [31:0]      win_start_r;
  logic [31:0]      win_len_r;
  logic [32:0]      win_end_r;

  logic             s1_valid_r;
  evt_t             s1_evt_r;
  logic [KEY_W-1:0] s1_key_r;

  logic [7:0]       cat_m;
  logic [7:0]       val_m;
  logic [KEY_W-1:0] in_key;
  logic             in_acc;

  logic             clr_busy;
  grp_flags_t       rd_flags;
  grp_flags_t       flags_nxt;
  logic             fire;
  logic             space_ok;
  res_push_t        push;
  res_t             out_res;

  assign cat_m  = mod_const({6'd0, in_group_category}, NUM_CATEGORIES);
  assign val_m  = mod_const(in_group_value, NUM_GROUP_VALUES);
  assign in_key = KEY_W'(int'(cat_m) * NUM_GROUP_VALUES + int'(val_m));

  // A last event holds off the next request until the flag store is cleared.
  assign in_ready = !clr_busy && (!s1_valid_r || (fire && !s1_evt_r.last));
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= '0;
      win_len_r   <= '0;
      win_end_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_START:  win_start_r <= cfg_wdata;
          CFG_WINDOW_LENGTH: win_len_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
      win_end_r <= {1'b0, win_start_r} + {1'b0, win_len_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_evt_r.delta   <= in_delta_ticks;
      s1_evt_r.kind    <= in_grouping_kind;
      s1_evt_r.cat     <= in_group_category;
      s1_evt_r.val     <= in_group_value;
      s1_evt_r.payload <= in_event_payload;
      s1_evt_r.last    <= in_is_last_event;
      s1_key_r         <= in_key;
    end
  end

  tegf_flag_mem #(
    .DEPTH (NUM_GROUPS),
    .AW    (KEY_W)
  ) u_flag_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_start (fire && s1_evt_r.last),
    .clr_busy  (clr_busy),
    .rd_en     (in_acc),
    .rd_addr   (in_key),
    .rd_data   (rd_flags),
    .wr_en     (fire),
    .wr_addr   (s1_key_r),
    .wr_data   (flags_nxt)
  );

  tegf_core #(
    .CNT_W (CNT_W)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (s1_valid_r),
    .evt       (s1_evt_r),
    .flags     (rd_flags),
    .space_ok  (space_ok),
    .win_start (win_start_r),
    .win_len   (win_len_r),
    .win_end   (win_end_r),
    .fire      (fire),
    .flags_nxt (flags_nxt),
    .push      (push)
  );

  tegf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_delta_ticks    = out_res.delta;
  assign out_grouping_kind  = out_res.kind;
  assign out_category       = out_res.cat;
  assign out_group_value    = out_res.val;
  assign out_payload        = out_res.payload;
  assign out_is_track_end   = out_res.track_end;
  assign out_excerpt_length = out_res.length;

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready)
    else $error("request taken during flag store clearing");
`endif

endmodule

// File: tb/track_excerpt_group_filter_unit_tb.sv
// Self-checking testbench for the track excerpt group filter unit.
// Predicts every excerpt result in SystemVerilog and checks the output stream.
// Depends on tegf_pkg and track_excerpt_group_filter_unit.
module track_excerpt_group_filter_unit_tb;
  import tegf_pkg::*;

  localparam int NUM_CATEGORIES   = 4;
  localparam int NUM_GROUP_VALUES = 256;
  localparam int NUM_GROUPS       = NUM_CATEGORIES * NUM_GROUP_VALUES;
  localparam int SETTLE_CYCLES    = 8;
  localparam int CYCLE_LIMIT      = 1_000_000;

  typedef enum logic [1:0] {SPAN_BEFORE, SPAN_INSIDE, SPAN_AFTER} span_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [23:0] in_delta_ticks = '0;
  logic [1:0]  in_grouping_kind = KIND_UNGROUPED;
  logic [1:0]  in_group_category = '0;
  logic [7:0]  in_group_value = '0;
  logic [31:0] in_event_payload = '0;
  logic        in_is_last_event = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_delta_ticks;
  logic [1:0]  out_grouping_kind;
  logic [1:0]  out_category;
  logic [7:0]  out_group_value;
  logic [31:0] out_payload;
  logic        out_is_track_end;
  logic [31:0] out_excerpt_length;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_WINDOW_START;
  logic [31:0] cfg_wdata = '0;

  track_excerpt_group_filter_unit #(
    .NUM_CATEGORIES  (NUM_CATEGORIES),
    .NUM_GROUP_VALUES(NUM_GROUP_VALUES)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_delta_ticks    (in_delta_ticks),
    .in_grouping_kind  (in_grouping_kind),
    .in_group_category (in_group_category),
    .in_group_value    (in_group_value),
    .in_event_payload  (in_event_payload),
    .in_is_last_event  (in_is_last_event),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_delta_ticks   (out_delta_ticks),
    .out_grouping_kind (out_grouping_kind),
    .out_category      (out_category),
    .out_group_value   (out_group_value),
    .out_payload       (out_payload),
    .out_is_track_end  (out_is_track_end),
    .out_excerpt_length(out_excerpt_length),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Window registers and excerpt state as the block should hold them.
  logic [31:0] win_start;
  logic [31:0] win_len;
  span_t       span;
  logic [32:0] tick_pos;
  logic        first_open;
  grp_flags_t  group_state [NUM_GROUPS];
  int          open_count;

  res_t        pending_results [$];
  int          fault_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cycle_count = 0;

  function automatic void clear_track();
    span       = SPAN_BEFORE;
    tick_pos   = '0;
    first_open = 1'b1;
    open_count = 0;
    foreach (group_state[k]) group_state[k] = '0;
  endfunction

  function automatic void predict_excerpt(input evt_t e);
    logic [32:0] wend;
    logic [32:0] t;
    logic [32:0] gap;
    logic [33:0] sum;
    int          key;
    logic        dropped;
    logic        emitted;
    res_t        r;
    wend    = {1'b0, win_start} + {1'b0, win_len};
    sum     = {1'b0, tick_pos} + 34'(e.delta);
    t       = sum[33] ? {33{1'b1}} : sum[32:0];
    key     = (int'(e.cat) % NUM_CATEGORIES) * NUM_GROUP_VALUES
              + (int'(e.val) % NUM_GROUP_VALUES);
    emitted = 1'b0;
    dropped = 1'b0;

    if (span == SPAN_BEFORE) begin
      if (t < {1'b0, win_start}) begin
        if (e.kind == KIND_START) group_state[key].at_start = 1'b1;
        else if (e.kind == KIND_END) group_state[key].at_start = 1'b0;
        tick_pos = t;
      end else begin
        span = SPAN_INSIDE;
      end
    end

    if (span == SPAN_INSIDE) begin
      if (t < wend) begin
        case (e.kind)
          KIND_START: begin
            if (!group_state[key].at_end) begin
              group_state[key].at_end = 1'b1;
              open_count++;
            end
          end
          KIND_END: begin
            // An end of a group opened before the window is swallowed.
            if (group_state[key].at_start) begin
              group_state[key].at_start = 1'b0;
              dropped = 1'b1;
            end else if (group_state[key].at_end) begin
              group_state[key].at_end = 1'b0;
              open_count--;
            end
          end
          KIND_ENCLOSED: dropped = group_state[key].at_start;
          default: ;
        endcase
        if (!dropped) begin
          r         = '0;
          r.delta   = 32'(e.delta);
          r.kind    = e.kind;
          r.cat     = e.cat;
          r.val     = e.val;
          r.payload = e.payload;
          if (first_open) begin
            r.delta    = (t >= {1'b0, win_start}) ? 32'(t - {1'b0, win_start}) : '0;
            first_open = 1'b0;
          end
          pending_results.push_back(r);
          emitted = 1'b1;
        end
        tick_pos = t;
      end else begin
        span       = SPAN_AFTER;
        first_open = 1'b1;
      end
    end

    // Past the window only the ends of groups still open are passed on.
    if (span == SPAN_AFTER && !emitted) begin
      if (open_count > 0 && e.kind == KIND_END && group_state[key].at_end) begin
        group_state[key].at_end = 1'b0;
        open_count--;
        r         = '0;
        r.kind    = e.kind;
        r.cat     = e.cat;
        r.val     = e.val;
        r.payload = e.payload;
        if (first_open) begin
          if (wend > tick_pos) begin
            gap     = wend - tick_pos;
            r.delta = (gap > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap[31:0];
          end
          first_open = 1'b0;
        end
        pending_results.push_back(r);
      end
    end

    if (e.last) begin
      r           = '0;
      r.track_end = 1'b1;
      r.length    = win_len;
      pending_results.push_back(r);
      clear_track();
    end
  endfunction

  function automatic evt_t make_event(input logic [23:0] d, input logic [1:0] k,
                                      input logic [1:0] c, input logic [7:0] v,
                                      input logic [31:0] p, input logic l);
    evt_t e;
    e.delta   = d;
    e.kind    = k;
    e.cat     = c;
    e.val     = v;
    e.payload = p;
    e.last    = l;
    return e;
  endfunction

  // Keys mostly come from a small pool so that starts and ends pair up.
  function automatic evt_t random_event(input int dmax, input logic l);
    evt_t e;
    e.delta = ($urandom_range(49) == 0) ? 24'($urandom) : 24'($urandom_range(0, dmax));
    case ($urandom_range(9))
      0, 1, 2: e.kind = KIND_START;
      3, 4, 5: e.kind = KIND_END;
      6, 7:    e.kind = KIND_ENCLOSED;
      default: e.kind = KIND_UNGROUPED;
    endcase
    if ($urandom_range(4) != 0) begin
      e.cat = 2'($urandom_range(0, 1));
      e.val = 8'($urandom_range(0, 3));
    end else begin
      e.cat = 2'($urandom);
      e.val = 8'($urandom);
    end
    e.payload = $urandom;
    e.last    = l;
    return e;
  endfunction

  task automatic send_event(input evt_t e);
    logic ready_seen;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid          <= 1'b1;
    in_delta_ticks    <= e.delta;
    in_grouping_kind  <= e.kind;
    in_group_category <= e.cat;
    in_group_value    <= e.val;
    in_event_payload  <= e.payload;
    in_is_last_event  <= e.last;
    // in_ready only moves at rising edges, so the value seen at the falling edge
    // is the one that the following rising edge acts on.
    do begin
      @(negedge clk);
      ready_seen = in_ready;
      @(posedge clk);
    end while (!ready_seen);
    predict_excerpt(e);
  endtask

  // Holds requests back until every predicted result has been seen.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] start_ticks, input logic [31:0] len_ticks);
    while (!in_ready) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_START;
    cfg_wdata <= start_ticks;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_LENGTH;
    cfg_wdata <= len_ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
    win_start = start_ticks;
    win_len   = len_ticks;
  endtask

  task automatic test_window_basics();
    wait_quiet();
    set_window(32'd10, 32'd20);
    send_event(make_event(24'd3, KIND_START, 2'd0, 8'd5, 32'h1234_5678, 1'b0));
    send_event(make_event(24'd2, KIND_START, 2'd3, 8'd255, 32'h0000_0001, 1'b0));
    send_event(make_event(24'd2, KIND_END, 2'd3, 8'd255, 32'h8000_0000, 1'b0));
    send_event(make_event(24'd5, KIND_ENCLOSED, 2'd0, 8'd5, 32'hA5A5_A5A5, 1'b0));
    send_event(make_event(24'd0, KIND_UNGROUPED, 2'd0, 8'd0, 32'hFFFF_FFFF, 1'b0));
    send_event(make_event(24'd1, KIND_START, 2'd1, 8'd7, 32'h0000_0000, 1'b0));
    send_event(make_event(24'd1, KIND_START, 2'd1, 8'd7, 32'h5A5A_5A5A, 1'b0));
    send_event(make_event(24'd1, KIND_END, 2'd0, 8'd5, 32'h0F0F_0F0F, 1'b0));
    send_event(make_event(24'd1, KIND_ENCLOSED, 2'd0, 8'd5, 32'hF0F0_F0F0, 1'b0));
    send_event(make_event(24'd1, KIND_START, 2'd2, 8'd0, 32'h1111_1111, 1'b0));
    send_event(make_event(24'd1, KIND_START, 2'd0, 8'd0, 32'h2222_2222, 1'b0));
    send_event(make_event(24'd0, KIND_END, 2'd0, 8'd0, 32'h3333_3333, 1'b0));
    send_event(make_event(24'hFF_FFFF, KIND_ENCLOSED, 2'd1, 8'd7, 32'h4444_4444, 1'b0));
    send_event(make_event(24'd0, KIND_END, 2'd3, 8'd3, 32'h5555_5555, 1'b0));
    send_event(make_event(24'd5, KIND_END, 2'd1, 8'd7, 32'h6666_6666, 1'b0));
    send_event(make_event(24'd0, KIND_END, 2'd2, 8'd0, 32'h7777_7777, 1'b1));
  endtask

  // The second event lands past the end while still before the window.
  task automatic test_empty_window();
    wait_quiet();
    set_window(32'd100, 32'd0);
    send_event(make_event(24'd50, KIND_START, 2'd2, 8'd9, 32'hDEAD_0001, 1'b0));
    send_event(make_event(24'hFF_FFFF, KIND_START, 2'd2, 8'd10, 32'hDEAD_0002, 1'b0));
    send_event(make_event(24'd0, KIND_END, 2'd2, 8'd9, 32'hDEAD_0003, 1'b1));
  endtask

  // Widening the window mid-track makes the first after-window delta saturate.
  task automatic test_late_group_end();
    wait_quiet();
    set_window(32'd0, 32'd2);
    send_event(make_event(24'd0, KIND_START, 2'd1, 8'd1, 32'hBEEF_0001, 1'b0));
    send_event(make_event(24'd5, KIND_UNGROUPED, 2'd0, 8'd0, 32'hBEEF_0002, 1'b0));
    wait_quiet();
    set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(make_event(24'd0, KIND_END, 2'd1, 8'd1, 32'hBEEF_0003, 1'b1));
  endtask

  task automatic test_random_tracks(input int n_events);
    int          sent;
    int          trk_len;
    int          dmax;
    int          span_est;
    logic [31:0] st;
    logic [31:0] ln;
    sent = 0;
    while (sent < n_events) begin
      trk_len = $urandom_range(6, 48);
      case ($urandom_range(3))
        0:       dmax = 1;
        1:       dmax = 8;
        2:       dmax = 64;
        default: dmax = 500;
      endcase
      span_est = trk_len * dmax / 2 + 1;
      st = $urandom_range(0, span_est / 2);
      ln = $urandom_range(0, span_est);
      case ($urandom_range(15))
        0: st = '0;
        1: ln = '0;
        2: st = '1;
        3: ln = '1;
        4: begin
          st = '0;
          ln = '0;
        end
        default: ;
      endcase
      wait_quiet();
      set_window(st, ln);
      for (int i = 0; i < trk_len; i++) begin
        if ($urandom_range(49) == 0) wait_quiet();
        send_event(random_event(dmax, i == trk_len - 1));
      end
      sent += trk_len;
    end
  endtask

  // Near-maximum deltas push the running time past 2^33 so the sum clamps.
  task automatic test_long_track();
    evt_t e;
    wait_quiet();
    set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 530; i++) begin
      e       = random_event(1, i == 529);
      e.delta = 24'hFF_FFFF - 24'($urandom_range(0, 15));
      send_event(e);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
    end
  endtask

  // Results and out_ready only move at rising edges, so a request seen here is
  // taken at the next rising edge.
  always @(negedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fault_count++;
        $display("%0t: result with nothing expected, expected none, actual delta %0h end %0b",
                 $time, out_delta_ticks, out_is_track_end);
      end else begin
        want = pending_results.pop_front();
        check_field("delta", want.delta, out_delta_ticks);
        check_field("kind", 32'(want.kind), 32'(out_grouping_kind));
        check_field("category", 32'(want.cat), 32'(out_category));
        check_field("group value", 32'(want.val), 32'(out_group_value));
        check_field("payload", want.payload, out_payload);
        check_field("track end", 32'(want.track_end), 32'(out_is_track_end));
        check_field("length", want.length, out_excerpt_length);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    win_start = '0;
    win_len   = '0;
    clear_track();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_window_basics();
    test_empty_window();
    test_late_group_end();

    send_idle_pct = 0;  recv_stall_pct = 0;
    test_random_tracks(150);
    send_idle_pct = 71; recv_stall_pct = 0;
    test_random_tracks(120);
    send_idle_pct = 0;  recv_stall_pct = 71;
    test_random_tracks(120);
    send_idle_pct = 11; recv_stall_pct = 11;
    test_random_tracks(110);
    test_long_track();

    wait_quiet();
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: track_excerpt_group_filter_unit.f
hw/rtl/tegf_pkg.sv
hw/rtl/tegf_flag_mem.sv
hw/rtl/tegf_core.sv
hw/rtl/tegf_out_fifo.sv
hw/rtl/track_excerpt_group_filter_unit.sv
tb/track_excerpt_group_filter_unit_tb.sv
